FILE: hw/rtl/form_param_stream_parser_assert.svh
// Assertion macros shared by the form parameter stream parser RTL.
`ifndef FORM_PARAM_STREAM_PARSER_ASSERT_SVH
`define FORM_PARAM_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FPSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpsp assertion failed");

// Next-cycle implication, checked outside reset.
`define FPSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpsp assertion failed");

`endif

FILE: hw/rtl/fpsp_pkg.sv
// Shared types, character constants and helpers of the form parameter stream parser.
package fpsp_pkg;

    localparam int unsigned CFG_ADDR_W = 3;

    // Register index, taken from paddr[2]
    localparam logic REG_PAIR_DELIMITER = 1'b0;

    localparam logic [7:0] DELIM_RESET = 8'h26;   // '&'
    localparam logic [7:0] CH_PLUS     = 8'h2B;   // '+'
    localparam logic [7:0] CH_PERCENT  = 8'h25;   // '%'
    localparam logic [7:0] CH_EQUAL    = 8'h3D;   // '='
    localparam logic [7:0] CH_SPACE    = 8'h20;   // ' '

    typedef enum logic [4:0] {
        PH_KEY  = 5'b00001,
        PH_VAL  = 5'b00010,
        PH_ESC1 = 5'b00100,
        PH_ESC2 = 5'b01000,
        PH_DEAD = 5'b10000
    } phase_t;

    // One classified input item
    typedef struct packed {
        logic [7:0] data;
        logic       eob;
        logic       is_delim;
        logic       is_equal;
        logic       is_percent;
        logic       is_plus;
        logic       is_zero;
        logic [3:0] nibble;
    } item_t;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       is_value;
        logic       pair_done;
        logic [6:0] pair_number;
        logic       over_capacity;
    } result_t;

    // Hex digit of either case; anything else reads as 0
    function automatic logic [3:0] hex_digit(input logic [7:0] b);
        logic [7:0] d;
        d = 8'd0;
        if (b >= 8'h30 && b <= 8'h39)
            d = b - 8'h30;
        else if (b >= 8'h41 && b <= 8'h46)
            d = b - 8'h37;
        else if (b >= 8'h61 && b <= 8'h66)
            d = b - 8'h57;
        return d[3:0];
    endfunction

endpackage

FILE: hw/rtl/fpsp_fifo.sv
// Small register-based first-in first-out queue of typed entries.
module fpsp_fifo #(
    parameter type         ENTRY_T = logic [7:0],
    parameter int unsigned DEPTH   = 4
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  ENTRY_T wr_data,
    output logic   full,
    input  logic   rd_en,
    output ENTRY_T rd_data,
    output logic   empty
);

    localparam int unsigned AW = $clog2(DEPTH);

    ENTRY_T          mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic            do_wr, do_rd;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: hw/rtl/fpsp_front.sv
// Front part: classifies each raw byte against the delimiter and special characters.
module fpsp_front (
    input  logic [7:0]          in_byte,
    input  logic                end_of_buffer,
    input  logic [7:0]          pair_delimiter,
    output fpsp_pkg::item_t     item
);

    always_comb
    begin
        item.data       = in_byte;
        item.eob        = end_of_buffer;
        item.is_delim   = (in_byte == pair_delimiter);
        item.is_equal   = (in_byte == fpsp_pkg::CH_EQUAL);
        item.is_percent = (in_byte == fpsp_pkg::CH_PERCENT);
        item.is_plus    = (in_byte == fpsp_pkg::CH_PLUS);
        item.is_zero    = (in_byte == 8'd0);
        item.nibble     = fpsp_pkg::hex_digit(in_byte);
    end

endmodule

FILE: hw/rtl/fpsp_back.sv
// Back: pair splitting and value decoding FSM, one item per cycle unless stalled.
module fpsp_back #(
    parameter int unsigned PAIR_CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fpsp_pkg::item_t     item,
    input  logic                item_avail,
    output logic                item_take,
    output fpsp_pkg::result_t   res,
    output logic                res_push,
    input  logic                res_full
);

    localparam int unsigned CNT_W = $clog2(PAIR_CAPACITY + 1);

    fpsp_pkg::phase_t   phase_reg, phase_next;
    logic               has_reg, has_next;
    logic [3:0]         hi_reg, hi_next;
    logic [CNT_W-1:0]   seen_reg, seen_next;
    logic [CNT_W+6:0]   seen_ext;
    logic [7:0]         decoded;
    logic               below_cap;
    logic               emit;

    assign below_cap = (seen_reg < CNT_W'(PAIR_CAPACITY));
    assign seen_ext  = {7'd0, seen_reg};
    assign decoded   = {hi_reg, item.nibble};

    always_comb
    begin
        phase_next        = phase_reg;
        has_next          = has_reg;
        hi_next           = hi_reg;
        seen_next         = seen_reg;
        res.out_byte      = 8'd0;
        res.byte_valid    = 1'b0;
        res.is_value      = 1'b0;
        res.pair_done     = 1'b0;
        res.pair_number   = seen_ext[6:0];
        res.over_capacity = !below_cap;

        if (!item.is_delim)
        begin
            has_next = 1'b1;
            unique case (phase_reg)
                fpsp_pkg::PH_KEY:
                begin
                    if (item.is_equal)
                        phase_next = fpsp_pkg::PH_VAL;
                    else
                    begin
                        res.out_byte   = item.data;
                        res.byte_valid = 1'b1;
                    end
                end
                fpsp_pkg::PH_VAL:
                begin
                    priority if (item.is_zero)
                        phase_next = fpsp_pkg::PH_DEAD;
                    else if (item.is_percent)
                        phase_next = fpsp_pkg::PH_ESC1;
                    else
                    begin
                        res.out_byte   = item.is_plus ? fpsp_pkg::CH_SPACE : item.data;
                        res.byte_valid = 1'b1;
                        res.is_value   = 1'b1;
                    end
                end
                fpsp_pkg::PH_ESC1:
                begin
                    if (item.is_zero)
                        phase_next = fpsp_pkg::PH_DEAD;
                    else
                    begin
                        hi_next    = item.nibble;
                        phase_next = fpsp_pkg::PH_ESC2;
                    end
                end
                fpsp_pkg::PH_ESC2:
                begin
                    // A decoded zero ends the value like a string terminator
                    if (item.is_zero || decoded == 8'd0)
                        phase_next = fpsp_pkg::PH_DEAD;
                    else
                    begin
                        res.out_byte   = decoded;
                        res.byte_valid = 1'b1;
                        res.is_value   = 1'b1;
                        phase_next     = fpsp_pkg::PH_VAL;
                    end
                end
                fpsp_pkg::PH_DEAD:
                    phase_next = fpsp_pkg::PH_DEAD;
                default:
                    phase_next = fpsp_pkg::PH_KEY;
            endcase
        end

        if (item.is_delim || item.eob)
        begin
            res.pair_done = has_next;
            if (has_next && below_cap)
                seen_next = seen_reg + 1'b1;
            phase_next = fpsp_pkg::PH_KEY;
            has_next   = 1'b0;
            hi_next    = 4'd0;
        end
    end

    // Items with no result retire even while the result queue is full
    assign emit      = res.byte_valid || res.pair_done;
    assign item_take = item_avail && (!emit || !res_full);
    assign res_push  = item_take && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fpsp_pkg::PH_KEY;
            has_reg   <= 1'b0;
            hi_reg    <= 4'd0;
            seen_reg  <= '0;
        end
        else if (item_take)
        begin
            phase_reg <= phase_next;
            has_reg   <= has_next;
            hi_reg    <= hi_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

FILE: hw/rtl/form_param_stream_parser.sv
// Top level of the form parameter stream parser: config register, queues, front and back.
//
//  channel   direction  handshake          payload
//  ------------------------------------------------------------------------------
//  input     in         push / full        in_byte, end_of_buffer
//  result    out        pop / empty        out_byte, byte_valid, is_value,
//                                          pair_done, pair_number, over_capacity
//  config    in         psel/penable/...   paddr, pwdata, prdata (pair_delimiter)
//
//  One item per cycle sustained unless a full result queue stalls a result: the back
//  state machine retires one classified item each cycle. A byte goes through the
//  middle queue and the back state machine into the result queue and its ports.
//  rst_n clears the queues, the state machine and the pair count, and loads '&'
//  as the delimiter; there is no clearing pass.
//  A full result queue stalls only items that make a result; the middle queue
//  absorbs it, and full rises once that queue is full.
`include "form_param_stream_parser_assert.svh"

module form_param_stream_parser #(
    parameter int unsigned PAIR_CAPACITY = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input item queue side
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      in_byte,
    input  logic                            end_of_buffer,
    // result queue side
    input  logic                            pop,
    output logic                            empty,
    output logic [7:0]                      out_byte,
    output logic                            byte_valid,
    output logic                            is_value,
    output logic                            pair_done,
    output logic [6:0]                      pair_number,
    output logic                            over_capacity,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpsp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int unsigned MID_DEPTH = 4;
    localparam int unsigned OUT_DEPTH = 2;
    localparam logic [6:0]  CAP_LOW7  = 7'(PAIR_CAPACITY);

    logic [7:0]         delim_reg;
    logic               cfg_wr;

    fpsp_pkg::item_t    front_item;
    fpsp_pkg::item_t    mid_item;
    logic               mid_empty;
    logic               back_take;

    fpsp_pkg::result_t  back_res;
    fpsp_pkg::result_t  out_res;
    logic               back_push;
    logic               out_full;

    // Config register: written at the access phase, read back any time
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == fpsp_pkg::REG_PAIR_DELIMITER);
    assign prdata = (paddr[2] == fpsp_pkg::REG_PAIR_DELIMITER) ? {24'd0, delim_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delim_reg <= fpsp_pkg::DELIM_RESET;
        else if (cfg_wr)
            delim_reg <= pwdata[7:0];
    end

    // Classify the incoming byte
    fpsp_front u_front (
        .in_byte        (in_byte),
        .end_of_buffer  (end_of_buffer),
        .pair_delimiter (delim_reg),
        .item           (front_item)
    );

    // Hold classified items between front and back
    fpsp_fifo #(
        .ENTRY_T (fpsp_pkg::item_t),
        .DEPTH   (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_item),
        .full    (full),
        .rd_en   (back_take),
        .rd_data (mid_item),
        .empty   (mid_empty)
    );

    // Advance the pair state machine
    fpsp_back #(
        .PAIR_CAPACITY (PAIR_CAPACITY)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (mid_item),
        .item_avail (!mid_empty),
        .item_take  (back_take),
        .res        (back_res),
        .res_push   (back_push),
        .res_full   (out_full)
    );

    // Park results until the consumer pops them
    fpsp_fifo #(
        .ENTRY_T (fpsp_pkg::result_t),
        .DEPTH   (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (back_push),
        .wr_data (back_res),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign out_byte      = out_res.out_byte;
    assign byte_valid    = out_res.byte_valid;
    assign is_value      = out_res.is_value;
    assign pair_done     = out_res.pair_done;
    assign pair_number   = out_res.pair_number;
    assign over_capacity = out_res.over_capacity;

    // A waiting result always carries a character or a pair close
    `FPSP_ASSERT_NOW(a_result_nonempty, clk, rst_n, !empty, byte_valid || pair_done)
    // Past capacity the pair index is pinned at the capacity
    `FPSP_ASSERT_NOW(a_over_pins_number, clk, rst_n, !empty && over_capacity, pair_number == CAP_LOW7)
    // The back never pushes a result into a full result queue, and pushes only with an item waiting
    `FPSP_ASSERT_NOW(a_no_push_on_full, clk, rst_n, back_push, !out_full && !mid_empty)
    // Once the queue fills, a result is waiting the next cycle
    `FPSP_ASSERT_NEXT(a_full_then_waiting, clk, rst_n, out_full && !pop, !empty)

endmodule
